// File: hw/rtl/ffba_pkg.sv
// Package with the shared types and codes of the first-fit block allocator.
package ffba_pkg;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RESIZE  = 2'd2;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE     = 3'd1;
    localparam logic [2:0] ST_NO_SPACE     = 3'd2;
    localparam logic [2:0] ST_UNKNOWN      = 3'd3;
    localparam logic [2:0] ST_ALREADY_FREE = 3'd4;

    localparam logic [1:0] CFG_MAX_REQUEST   = 2'd0;
    localparam logic [1:0] CFG_HEAP_CAPACITY = 2'd1;
    localparam logic [1:0] CFG_HEADER_BYTES  = 2'd2;

    localparam logic [26:0] MAX_REQUEST_RST   = 27'd100000000;
    localparam logic [31:0] HEAP_CAPACITY_RST = 32'd16777216;
    localparam logic [7:0]  HEADER_BYTES_RST  = 8'd32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

    // Search token that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic        vld;
        logic [31:0] addr;
        logic [26:0] size;
        logic        m_hit;
        logic [26:0] m_size;
        logic        m_free;
        logic        f_hit;
        logic [26:0] f_size;
        logic [31:0] f_pay;
    } t_query;

    // Table update issued when an operation commits.
    typedef struct packed {
        logic        take_en;
        logic        rel_en;
        logic        new_en;
        logic [31:0] new_base;
        logic [26:0] new_size;
    } t_cell_wr;

endpackage

// File: hw/rtl/ffba_cell.sv
// One table entry of the allocator together with its stage of the search chain.
module ffba_cell import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = 64,
    parameter int IDX = 0,
    localparam int IW = $clog2(MAX_BLOCKS),
    localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [CW-1:0] i_count,
    input  logic [7:0]    i_hdr,
    input  t_query        i_q,
    input  logic [IW-1:0] i_m_idx,
    input  logic [IW-1:0] i_f_idx,
    output t_query        o_q,
    output logic [IW-1:0] o_m_idx,
    output logic [IW-1:0] o_f_idx,
    input  t_cell_wr      i_wr,
    input  logic [IW-1:0] i_take_idx,
    input  logic [IW-1:0] i_rel_idx,
    input  logic [IW-1:0] i_new_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic [31:0] r_base;
    logic [26:0] r_size;
    logic        r_free;
    t_query      r_q;
    logic [IW-1:0] r_m_idx;
    logic [IW-1:0] r_f_idx;

    t_query        n_q;
    logic [IW-1:0] n_m_idx;
    logic [IW-1:0] n_f_idx;
    logic [31:0]   pay;
    logic          own_ok;

    always_comb begin
        pay     = r_base + {24'd0, i_hdr};
        own_ok  = MY_CNT < i_count;
        n_q     = i_q;
        n_m_idx = i_m_idx;
        n_f_idx = i_f_idx;
        // Only the first matching entry is kept, as the scan runs upward.
        if (i_q.vld && !i_q.m_hit && own_ok && pay == i_q.addr) begin
            n_q.m_hit  = 1'b1;
            n_q.m_size = r_size;
            n_q.m_free = r_free;
            n_m_idx    = MY_IDX;
        end
        if (i_q.vld && !i_q.f_hit && own_ok && r_free && r_size >= i_q.size) begin
            n_q.f_hit  = 1'b1;
            n_q.f_size = r_size;
            n_q.f_pay  = pay;
            n_f_idx    = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else begin
            r_q.vld <= n_q.vld;
        end
        r_q.addr   <= n_q.addr;
        r_q.size   <= n_q.size;
        r_q.m_hit  <= n_q.m_hit;
        r_q.m_size <= n_q.m_size;
        r_q.m_free <= n_q.m_free;
        r_q.f_hit  <= n_q.f_hit;
        r_q.f_size <= n_q.f_size;
        r_q.f_pay  <= n_q.f_pay;
        r_m_idx    <= n_m_idx;
        r_f_idx    <= n_f_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.new_en && i_new_idx == MY_IDX) begin
            r_base <= i_wr.new_base;
            r_size <= i_wr.new_size;
            r_free <= 1'b0;
        end else if (i_wr.take_en && i_take_idx == MY_IDX) begin
            r_free <= 1'b0;
        end else if (i_wr.rel_en && i_rel_idx == MY_IDX) begin
            r_free <= 1'b1;
        end
    end

    assign o_q     = r_q;
    assign o_m_idx = r_m_idx;
    assign o_f_idx = r_f_idx;

endmodule

// File: hw/rtl/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator: controller, counters and the row of cells.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   operation, request_size, payload_address
//  m_axis    out        m_axis_tvalid/m_axis_tready   status, address and usage counters
//  cfg       in         i_cfg_valid/o_cfg_ready       register index and write data
//
// For each operation the search token walks the row one cell per cycle, then it is captured
// and, in the done state, the update is committed.
// A result beat waits in the output register while the next item is already searched;
// a commit stalls only while that register is still full.
// Reset is synchronous; table entries are not cleared, since only entries below the
// block count are ever looked at. Configuration writes are always ready.
module first_fit_block_allocator_unit import ffba_pkg::*; #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] operation, [28:2] request_size, [60:29] payload_address
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [34:3] result_address, [41:35] free_block_count,
    // [73:42] free_byte_total, [80:74] block_count, [112:81] block_byte_total,
    // [126:113] header_byte_total
    output logic [127:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

    t_state r_state, n_state;

    logic [26:0] r_max_req;
    logic [31:0] r_cap;
    logic [7:0]  r_hdr;

    logic [CW-1:0] r_count;
    logic [31:0]   r_top;
    logic [CW-1:0] r_fblocks;
    logic [31:0]   r_fbytes;
    logic [31:0]   r_total;

    logic [1:0]    r_op;
    t_query        r_res;
    logic [IW-1:0] r_m_idx;
    logic [IW-1:0] r_f_idx;

    logic          r_ovld;
    logic [127:0]  r_odata;

    t_query        q_chain [MAX_BLOCKS+1];
    logic [IW-1:0] m_chain [MAX_BLOCKS+1];
    logic [IW-1:0] f_chain [MAX_BLOCKS+1];

    logic     in_acc;
    logic     commit;
    t_cell_wr wr;

    // Commit-time decode.
    logic          bad;
    logic          alloc_req;
    logic          use_fit;
    logic          use_new;
    logic          rel;
    logic [33:0]   need;
    logic [2:0]    status;
    logic [31:0]   res_addr;
    logic [CW-1:0] n_count;
    logic [CW-1:0] n_fblocks;
    logic [31:0]   n_fbytes;
    logic [31:0]   n_total;
    logic [CW+7:0] hdr_total;

    assign in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_acc) n_state = S_SEARCH;
            S_SEARCH: if (q_chain[MAX_BLOCKS].vld) n_state = S_DONE;
            S_DONE:   if (!r_ovld || m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = r_state == S_IDLE;
        commit        = r_state == S_DONE && (!r_ovld || m_axis_tready);
    end

    always_comb begin
        q_chain[0]        = '0;
        q_chain[0].vld    = in_acc;
        q_chain[0].size   = s_axis_tdata[28:2];
        q_chain[0].addr   = s_axis_tdata[60:29];
        m_chain[0]        = '0;
        f_chain[0]        = '0;
    end

    always_comb begin
        bad       = r_res.size == 27'd0 || r_res.size > r_max_req;
        alloc_req = r_op == OP_ALLOC ||
                    (r_op == OP_RESIZE && (r_res.addr == 32'd0 ||
                     (r_res.m_hit && r_res.m_size < r_res.size)));
        need      = {2'b00, r_top} + {26'd0, r_hdr} + {7'd0, r_res.size};
        use_fit   = alloc_req && !bad && r_res.f_hit;
        use_new   = alloc_req && !bad && !r_res.f_hit && r_count < CNT_MAX &&
                    need <= {2'b00, r_cap};
        rel       = r_res.addr != 32'd0 && r_res.m_hit && !r_res.m_free &&
                    (r_op == OP_RELEASE ||
                     (r_op == OP_RESIZE && r_res.m_size < r_res.size &&
                      (use_fit || use_new)));
        status    = ST_OK;
        res_addr  = 32'd0;
        if (alloc_req) begin
            if (bad) begin
                status = ST_BAD_SIZE;
            end else if (use_fit) begin
                res_addr = r_res.f_pay;
            end else if (use_new) begin
                res_addr = r_top + {24'd0, r_hdr};
            end else begin
                status = ST_NO_SPACE;
            end
        end else if ((r_op == OP_RELEASE || r_op == OP_RESIZE) && r_res.addr != 32'd0) begin
            if (!r_res.m_hit) begin
                status = ST_UNKNOWN;
            end else if (r_op == OP_RESIZE) begin
                res_addr = r_res.addr;
            end else if (r_res.m_free) begin
                status = ST_ALREADY_FREE;
            end
        end
        n_count   = r_count + CW'(use_new);
        n_fblocks = r_fblocks - CW'(use_fit) + CW'(rel);
        n_fbytes  = r_fbytes - (use_fit ? {5'd0, r_res.f_size} : 32'd0)
                             + (rel ? {5'd0, r_res.m_size} : 32'd0);
        n_total   = r_total + (use_new ? {5'd0, r_res.size} : 32'd0);
        hdr_total = (CW+8)'(n_count) * (CW+8)'(r_hdr);
    end

    always_comb begin
        wr.take_en  = commit && use_fit;
        wr.rel_en   = commit && rel;
        wr.new_en   = commit && use_new;
        wr.new_base = r_top;
        wr.new_size = r_res.size;
    end

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffba_cell #(
            .MAX_BLOCKS (MAX_BLOCKS),
            .IDX        (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_count    (r_count),
            .i_hdr      (r_hdr),
            .i_q        (q_chain[g]),
            .i_m_idx    (m_chain[g]),
            .i_f_idx    (f_chain[g]),
            .o_q        (q_chain[g+1]),
            .o_m_idx    (m_chain[g+1]),
            .o_f_idx    (f_chain[g+1]),
            .i_wr       (wr),
            .i_take_idx (r_f_idx),
            .i_rel_idx  (r_m_idx),
            .i_new_idx  (r_count[IW-1:0])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_max_req <= MAX_REQUEST_RST;
            r_cap     <= HEAP_CAPACITY_RST;
            r_hdr     <= HEADER_BYTES_RST;
            r_count   <= '0;
            r_top     <= 32'd0;
            r_fblocks <= '0;
            r_fbytes  <= 32'd0;
            r_total   <= 32'd0;
            r_ovld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAX_REQUEST:   r_max_req <= i_cfg_data[26:0];
                    CFG_HEAP_CAPACITY: r_cap     <= i_cfg_data;
                    CFG_HEADER_BYTES:  r_hdr     <= i_cfg_data[7:0];
                    default:           ;
                endcase
            end
            if (commit) begin
                r_count   <= n_count;
                r_fblocks <= n_fblocks;
                r_fbytes  <= n_fbytes;
                r_total   <= n_total;
                if (use_new) begin
                    r_top <= need[31:0];
                end
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op <= s_axis_tdata[1:0];
        end
        if (r_state == S_SEARCH && q_chain[MAX_BLOCKS].vld) begin
            r_res   <= q_chain[MAX_BLOCKS];
            r_m_idx <= m_chain[MAX_BLOCKS];
            r_f_idx <= f_chain[MAX_BLOCKS];
        end
        if (commit) begin
            r_odata <= {1'b0, hdr_total[13:0], n_total, 7'(n_count), n_fbytes,
                        7'(n_fblocks), res_addr, status};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

    a_acc_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_SEARCH)
        else $error("accepted beat did not start a search");
    a_token_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_chain[MAX_BLOCKS].vld |-> r_state == S_SEARCH)
        else $error("search token left the row outside a search");
    a_free_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fblocks <= r_count)
        else $error("free block count exceeds block count");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("block count exceeds table depth");

endmodule

// File: dv/first_fit_block_allocator_unit_tb.sv
// Self-checking testbench of the first-fit block allocator with a built-in table predictor.
`timescale 1ns / 1ps

module first_fit_block_allocator_unit_tb;
    import ffba_pkg::*;

    localparam int         TABLE_DEPTH = 64;
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         IDLE_LIMIT  = 4000;

    // Members run from the highest bits of the result beat down to the lowest.
    typedef struct packed {
        logic [13:0] header_total;
        logic [31:0] block_bytes;
        logic [6:0]  blocks;
        logic [31:0] free_bytes;
        logic [6:0]  free_blocks;
        logic [31:0] address;
        logic [2:0]  status;
    } t_alloc_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    first_fit_block_allocator_unit #(.MAX_BLOCKS(TABLE_DEPTH)) DUT (.*);

    // Predicted allocator state.
    logic [26:0] lim_request;
    logic [31:0] lim_capacity;
    logic [7:0]  hdr_bytes;
    logic [31:0] blk_base [TABLE_DEPTH];
    logic [26:0] blk_size [TABLE_DEPTH];
    logic        blk_free [TABLE_DEPTH];
    int          blk_used;
    logic [31:0] brk_top;
    logic [6:0]  free_cnt;
    logic [31:0] free_sum;
    logic [31:0] carved_sum;

    t_alloc_result pending_results[$];
    int            mismatches;
    int            idle_cycles;
    bit            steady;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic int lookup_block(logic [31:0] addr);
        for (int i = 0; i < blk_used; i++)
            if (blk_base[i] + 32'(hdr_bytes) == addr) return i;
        return -1;
    endfunction

    function automatic logic [2:0] grant_block(logic [26:0] size, output logic [31:0] addr);
        logic [32:0] need;
        addr = '0;
        if (size == 0 || size > lim_request) return ST_BAD_SIZE;
        for (int i = 0; i < blk_used; i++) begin
            if (blk_free[i] && blk_size[i] >= size) begin
                blk_free[i] = 1'b0;
                free_cnt = free_cnt - 1;
                free_sum = free_sum - 32'(blk_size[i]);
                addr = blk_base[i] + 32'(hdr_bytes);
                return ST_OK;
            end
        end
        if (blk_used >= TABLE_DEPTH) return ST_NO_SPACE;
        need = 33'(brk_top) + 33'(hdr_bytes) + 33'(size);
        if (need > 33'(lim_capacity)) return ST_NO_SPACE;
        blk_base[blk_used] = brk_top;
        blk_size[blk_used] = size;
        blk_free[blk_used] = 1'b0;
        addr = brk_top + 32'(hdr_bytes);
        blk_used++;
        brk_top = need[31:0];
        carved_sum = carved_sum + 32'(size);
        return ST_OK;
    endfunction

    function automatic logic [2:0] mark_free(int idx);
        if (blk_free[idx]) return ST_ALREADY_FREE;
        blk_free[idx] = 1'b1;
        free_cnt = free_cnt + 1;
        free_sum = free_sum + 32'(blk_size[idx]);
        return ST_OK;
    endfunction

    function automatic t_alloc_result predict_heap_op(logic [1:0] op, logic [26:0] size,
                                                      logic [31:0] addr);
        t_alloc_result res;
        int            idx;
        res = '0;
        case (op)
            OP_ALLOC: res.status = grant_block(size, res.address);
            OP_RELEASE: begin
                if (addr != 0) begin
                    idx = lookup_block(addr);
                    res.status = (idx < 0) ? ST_UNKNOWN : mark_free(idx);
                end
            end
            OP_RESIZE: begin
                if (addr == 0) begin
                    res.status = grant_block(size, res.address);
                end else begin
                    idx = lookup_block(addr);
                    if (idx < 0) begin
                        res.status = ST_UNKNOWN;
                    end else if (blk_size[idx] >= size) begin
                        res.address = addr;
                    end else begin
                        res.status = grant_block(size, res.address);
                        if (res.status == ST_OK) void'(mark_free(idx));
                    end
                end
            end
            default: ;
        endcase
        res.free_blocks  = free_cnt;
        res.free_bytes   = free_sum;
        res.blocks       = 7'(blk_used);
        res.block_bytes  = carved_sum;
        res.header_total = 14'(blk_used * int'(hdr_bytes));
        return res;
    endfunction

    task automatic send_heap_op(logic [1:0] op, logic [26:0] size, logic [31:0] addr);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {3'b000, addr, size, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_heap_op(op, size, addr));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // Let the commit of the last beat settle before touching registers.
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_index <= index;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_MAX_REQUEST:   lim_request  = value[26:0];
            CFG_HEAP_CAPACITY: lim_capacity = value;
            CFG_HEADER_BYTES:  hdr_bytes    = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] live_address();
        if (blk_used == 0) return 32'(hdr_bytes);
        return blk_base[$urandom_range(0, blk_used - 1)] + 32'(hdr_bytes);
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got 0x%08h expected 0x%08h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_alloc_result got;
        t_alloc_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[126:0];
            if (pending_results.size() == 0) begin
                report("unexpected beat", 32'(got.status), 32'(ST_OK));
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report("status", 32'(got.status), 32'(want.status));
                if (got.address != want.address)
                    report("result_address", got.address, want.address);
                if (got.free_blocks != want.free_blocks)
                    report("free_block_count", 32'(got.free_blocks), 32'(want.free_blocks));
                if (got.free_bytes != want.free_bytes)
                    report("free_byte_total", got.free_bytes, want.free_bytes);
                if (got.blocks != want.blocks)
                    report("block_count", 32'(got.blocks), 32'(want.blocks));
                if (got.block_bytes != want.block_bytes)
                    report("block_byte_total", got.block_bytes, want.block_bytes);
                if (got.header_total != want.header_total)
                    report("header_byte_total", 32'(got.header_total),
                           32'(want.header_total));
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        int stall_left;
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL first_fit_block_allocator_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_directed();
        logic [31:0] a0;
        logic [31:0] a1;
        send_heap_op(OP_UNUSED, 27'h7ffffff, 32'hffffffff);
        send_heap_op(OP_RELEASE, 27'd5, 32'd0);
        send_heap_op(OP_RELEASE, 27'd0, 32'd12345);
        send_heap_op(OP_ALLOC, 27'd0, 32'd0);
        send_heap_op(OP_ALLOC, 27'd100000001, 32'd0);
        send_heap_op(OP_ALLOC, 27'd100000000, 32'd0);
        a0 = live_address();
        send_heap_op(OP_ALLOC, 27'd100, 32'd0);
        a1 = blk_base[0] + 32'(hdr_bytes);
        send_heap_op(OP_RELEASE, 27'd0, a1);
        send_heap_op(OP_RELEASE, 27'd0, a1);
        send_heap_op(OP_ALLOC, 27'd100, 32'd0);
        send_heap_op(OP_RESIZE, 27'd0, a1);
        send_heap_op(OP_RESIZE, 27'd100, a1);
        send_heap_op(OP_RELEASE, 27'd0, a1);
        send_heap_op(OP_RESIZE, 27'd50, a1);
        send_heap_op(OP_RESIZE, 27'd200, a1);
        send_heap_op(OP_RESIZE, 27'd300, a0 + 1);
        send_heap_op(OP_RESIZE, 27'd20, 32'd0);
        send_heap_op(OP_RESIZE, 27'd0, 32'd0);
        send_heap_op(OP_RESIZE, 27'd100000001, a1);
        send_heap_op(OP_RESIZE, 27'd16777216, a0);
    endtask

    task automatic random_heap_op();
        logic [1:0]  op;
        logic [26:0] size;
        logic [31:0] addr;
        int          r;
        r = $urandom_range(0, 99);
        op = (r < 40) ? OP_ALLOC : (r < 70) ? OP_RELEASE : (r < 96) ? OP_RESIZE : OP_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 82)      size = 27'($urandom_range(1, 256));
        else if (r < 88) size = 27'($urandom_range(257, 4096));
        else if (r < 93) size = 27'd0;
        else if (r < 97) size = 27'($urandom);
        else             size = lim_request + 27'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 84)      addr = live_address();
        else if (r < 89) addr = 32'd0;
        else if (r < 94) addr = live_address() ^ (32'd1 << $urandom_range(0, 31));
        else             addr = $urandom;
        send_heap_op(op, size, addr);
    endtask

    task automatic test_random_phases();
        write_reg(CFG_HEAP_CAPACITY, 32'd4000);
        write_reg(CFG_HEADER_BYTES, 32'd8);
        repeat (250) random_heap_op();
        write_reg(CFG_HEAP_CAPACITY, 32'(HEAP_CAPACITY_RST));
        write_reg(CFG_MAX_REQUEST, 32'd2000);
        steady = 1'b1;
        repeat (250) random_heap_op();
        steady = 1'b0;
        write_reg(CFG_HEADER_BYTES, 32'd255);
        write_reg(CFG_MAX_REQUEST, 32'd1);
        repeat (150) random_heap_op();
        write_reg(CFG_MAX_REQUEST, 32'(MAX_REQUEST_RST));
        write_reg(CFG_HEADER_BYTES, 32'($urandom_range(9, 254)));
        repeat (300) random_heap_op();
        write_reg(CFG_HEAP_CAPACITY, 32'd0);
        repeat (200) random_heap_op();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_MAX_REQUEST, 32'h07ffffff);
        write_reg(CFG_HEAP_CAPACITY, 32'hffffffff);
        write_reg(CFG_HEADER_BYTES, 32'd8);
        send_heap_op(OP_ALLOC, 27'h7ffffff, 32'd0);
        send_heap_op(OP_RESIZE, 27'h7ffffff, 32'd0);
        send_heap_op(OP_RESIZE, 27'h5555555, live_address());
        send_heap_op(OP_RELEASE, 27'h2aaaaaa, 32'haaaaaaaa);
        send_heap_op(OP_RELEASE, 27'd0, 32'h55555555);
        repeat (150) random_heap_op();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_MAX_REQUEST;
        i_cfg_data    = '0;
        idle_cycles   = 0;
        mismatches    = 0;
        steady        = 1'b0;
        lim_request   = MAX_REQUEST_RST;
        lim_capacity  = HEAP_CAPACITY_RST;
        hdr_bytes     = HEADER_BYTES_RST;
        blk_used      = 0;
        brk_top       = '0;
        free_cnt      = '0;
        free_sum      = '0;
        carved_sum    = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_phases();
        test_config_extremes();
        drain_results();

        if (mismatches == 0) begin
            $display("PASS first_fit_block_allocator_unit");
        end else begin
            $display("FAIL first_fit_block_allocator_unit");
        end
        $finish;
    end

endmodule
